>>> rtl/core/psfs_pkg.sv
package psfs_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int TABLE_ENTRIES_MAX = 256;
	localparam int IDX_MAX_W = 8;
	localparam int FILL_MAX_W = 9;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_ARRIVAL = 2'd0,
		CMD_QUERY   = 2'd1,
		CMD_TOTALS  = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_HEAD = 2'd0,
		KIND_BODY = 2'd1,
		KIND_TAIL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_WARMUP = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_MISS   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_REPORT = 3'd0,
		OP_NEW    = 3'd1,
		OP_UPDATE = 3'd2,
		OP_QUERY  = 3'd3,
		OP_TOTALS = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_APPLY = 4'b0010,
		S_SUM   = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [31:0] packets;
		logic [31:0] tails;
		logic [31:0] flits;
		logic [47:0] delay_sum;
		logic [47:0] net_delay_sum;
		logic [31:0] max_delay;
		logic [31:0] last_time;
	} stats_t;

	typedef struct packed {
		op_t                   op;
		status_t               status;
		logic [IDX_MAX_W-1:0]  idx;
		logic [FILL_MAX_W-1:0] fill;
		logic                  head;
		logic                  tail;
		logic [31:0]           delay;
		logic [31:0]           net_delay;
		logic [31:0]           last_time;
	} item_t;

	typedef struct packed {
		status_t               status;
		stats_t                stats;
		logic [FILL_MAX_W-1:0] fill;
	} result_t;

	function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
	endfunction

	function automatic logic [31:0] max32(input logic [31:0] a, input logic [31:0] b);
		return (b > a) ? b : a;
	endfunction

	function automatic stats_t apply_flit(input stats_t r, input item_t it);
		stats_t u;
		u = r;
		if (it.head) begin
			u.packets = sat32(r.packets, 32'd1);
			u.delay_sum = sat48(r.delay_sum, {16'd0, it.delay});
			u.net_delay_sum = sat48(r.net_delay_sum, {16'd0, it.net_delay});
			u.max_delay = max32(r.max_delay, it.delay);
		end
		if (it.tail) begin
			u.tails = sat32(r.tails, 32'd1);
		end
		u.flits = sat32(r.flits, 32'd1);
		u.last_time = it.last_time;
		return u;
	endfunction

	function automatic stats_t accumulate(input stats_t a, input stats_t r);
		stats_t u;
		u.packets = sat32(a.packets, r.packets);
		u.tails = sat32(a.tails, r.tails);
		u.flits = sat32(a.flits, r.flits);
		u.delay_sum = sat48(a.delay_sum, r.delay_sum);
		u.net_delay_sum = sat48(a.net_delay_sum, r.net_delay_sum);
		u.max_delay = max32(a.max_delay, r.max_delay);
		u.last_time = max32(a.last_time, r.last_time);
		return u;
	endfunction

endpackage

>>> rtl/core/psfs_in_if.sv
interface psfs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] arrive_cycle;
	logic [7:0]  source_id;
	logic [1:0]  flit_kind;
	logic [31:0] inject_stamp;
	logic [31:0] network_stamp;

	modport source(output valid, command, arrive_cycle, source_id, flit_kind,
		inject_stamp, network_stamp, input ready);
	modport sink(input valid, command, arrive_cycle, source_id, flit_kind,
		inject_stamp, network_stamp, output ready);
endinterface

>>> rtl/core/psfs_out_if.sv
interface psfs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] packet_count;
	logic [31:0] tail_count;
	logic [31:0] flit_count;
	logic [47:0] delay_sum;
	logic [47:0] network_delay_sum;
	logic [31:0] max_delay;
	logic [31:0] last_flit_time;
	logic [5:0]  sources_in_use;

	modport source(output valid, status, packet_count, tail_count, flit_count,
		delay_sum, network_delay_sum, max_delay, last_flit_time, sources_in_use,
		input ready);
	modport sink(input valid, status, packet_count, tail_count, flit_count,
		delay_sum, network_delay_sum, max_delay, last_flit_time, sources_in_use,
		output ready);
endinterface

>>> rtl/core/per_source_flit_statistics_unit.sv
// Channel    Dir  Transfer carries
// flit_in    in   command, arrival time, source, flit kind, two time stamps
// stat_out   out  status, per-source or total counters, sources in use
// apb        in   warm-up cycles at 0x0, reset offset at 0x4
//
// The front classifies a transfer in its accept cycle and queues it.
// In the back an arrival or a single query goes through pop with table read, update and
// write (a query only reads), then output load. A totals query reads the allocated entries
// from the statistics memory one per cycle and sums them before the output load; any other
// result goes from pop straight to output load.
// Reset clears the table valid bits and fill count at once; no sweep is needed.
// Each side stalls on its own through the queue and the output register.
module per_source_flit_statistics_unit #(
	parameter int TABLE_ENTRIES = psfs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	psfs_in_if.sink     flit_in,
	psfs_out_if.source  stat_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [31:0]     warm_up_q;
	logic [31:0]     offset_q;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;
	psfs_pkg::item_t push_item;
	psfs_pkg::item_t head_item;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? offset_q : warm_up_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_up_q <= '0;
			offset_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				offset_q <= pwdata;
			end else begin
				warm_up_q <= pwdata;
			end
		end
	end

	psfs_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.flit_in(flit_in),
		.warm_up_cycles(warm_up_q),
		.reset_offset(offset_q),
		.queue_full(full),
		.push(push),
		.push_item(push_item)
	);

	psfs_fifo #(
		.DEPTH(psfs_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(full),
		.pop(pop),
		.head_item(head_item),
		.empty(empty)
	);

	psfs_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.queue_empty(empty),
		.head_item(head_item),
		.pop(pop),
		.stat_out(stat_out)
	);
endmodule

>>> rtl/core/psfs_ram.sv
module psfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/core/psfs_fifo.sv
module psfs_fifo #(
	parameter int DEPTH = psfs_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  psfs_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output psfs_pkg::item_t head_item,
	output logic            empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	psfs_pkg::item_t   slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

>>> rtl/core/psfs_front.sv
module psfs_front #(
	parameter int TABLE_ENTRIES = psfs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	psfs_in_if.sink         flit_in,
	input  logic [31:0]     warm_up_cycles,
	input  logic [31:0]     reset_offset,
	input  logic            queue_full,
	output logic            push,
	output psfs_pkg::item_t push_item
);
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

	logic [7:0]        tag_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [FILL_W-1:0] fill_q;

	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic              in_warmup;
	logic              has_room;
	logic              alloc;
	logic              clear;
	logic [FILL_W-1:0] fill_next;

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
			if (valid_q[k] && tag_q[k] == flit_in.source_id) begin
				hit = 1'b1;
				hit_idx = IDX_W'(k);
			end
		end
	end

	assign in_warmup = {1'b0, flit_in.arrive_cycle} <
		({1'b0, reset_offset} + {1'b0, warm_up_cycles});
	assign has_room = fill_q < FILL_W'(TABLE_ENTRIES);
	assign flit_in.ready = !queue_full;
	assign push = flit_in.valid && !queue_full;

	always_comb begin
		push_item = '0;
		push_item.op = psfs_pkg::OP_REPORT;
		push_item.status = psfs_pkg::STAT_DONE;
		push_item.idx = psfs_pkg::IDX_MAX_W'(hit_idx);
		push_item.head = (psfs_pkg::kind_t'(flit_in.flit_kind) == psfs_pkg::KIND_HEAD);
		push_item.tail = (psfs_pkg::kind_t'(flit_in.flit_kind) == psfs_pkg::KIND_TAIL);
		push_item.delay = (flit_in.arrive_cycle >= flit_in.inject_stamp) ?
			flit_in.arrive_cycle - flit_in.inject_stamp : 32'd0;
		push_item.net_delay = (flit_in.arrive_cycle >= flit_in.network_stamp) ?
			flit_in.arrive_cycle - flit_in.network_stamp : 32'd0;
		push_item.last_time = flit_in.arrive_cycle - warm_up_cycles;
		alloc = 1'b0;
		clear = 1'b0;
		case (psfs_pkg::cmd_t'(flit_in.command))
			psfs_pkg::CMD_ARRIVAL: begin
				if (in_warmup) begin
					push_item.status = psfs_pkg::STAT_WARMUP;
				end else if (hit) begin
					push_item.op = psfs_pkg::OP_UPDATE;
				end else if (has_room) begin
					push_item.op = psfs_pkg::OP_NEW;
					push_item.idx = psfs_pkg::IDX_MAX_W'(fill_q[IDX_W-1:0]);
					alloc = 1'b1;
				end else begin
					push_item.status = psfs_pkg::STAT_FULL;
				end
			end
			psfs_pkg::CMD_QUERY: begin
				if (hit) begin
					push_item.op = psfs_pkg::OP_QUERY;
				end else begin
					push_item.status = psfs_pkg::STAT_MISS;
				end
			end
			psfs_pkg::CMD_TOTALS: begin
				push_item.op = psfs_pkg::OP_TOTALS;
			end
			psfs_pkg::CMD_CLEAR: begin
				clear = 1'b1;
			end
			default: begin
				push_item.op = psfs_pkg::OP_REPORT;
			end
		endcase
		fill_next = clear ? '0 : (alloc ? fill_q + 1'b1 : fill_q);
		push_item.fill = psfs_pkg::FILL_MAX_W'(fill_next);
	end

	always_ff @(posedge clk) begin
		if (push && alloc) begin
			tag_q[fill_q[IDX_W-1:0]] <= flit_in.source_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q <= '0;
		end else if (push) begin
			if (clear) begin
				valid_q <= '0;
			end else if (alloc) begin
				valid_q[fill_q[IDX_W-1:0]] <= 1'b1;
			end
			fill_q <= fill_next;
		end
	end
endmodule

>>> rtl/core/psfs_back.sv
module psfs_back #(
	parameter int TABLE_ENTRIES = psfs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            queue_empty,
	input  psfs_pkg::item_t head_item,
	output logic            pop,
	psfs_out_if.source      stat_out
);
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
	localparam int REC_W = $bits(psfs_pkg::stats_t);

	psfs_pkg::state_t  state_q;
	psfs_pkg::item_t   item_q;
	psfs_pkg::stats_t  acc_q;
	psfs_pkg::result_t res_q;
	psfs_pkg::result_t out_q;
	logic              out_valid_q;
	logic [FILL_W-1:0] cnt_q;

	logic              re;
	logic [IDX_W-1:0]  raddr;
	logic              we;
	logic [REC_W-1:0]  rdata;
	psfs_pkg::stats_t  rec;
	psfs_pkg::stats_t  upd;
	psfs_pkg::stats_t  acc_next;
	logic              load_out;
	logic              sum_done;

	psfs_ram #(
		.WIDTH(REC_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(item_q.idx[IDX_W-1:0]),
		.wdata(upd),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rec = (item_q.op == psfs_pkg::OP_NEW) ? '0 : psfs_pkg::stats_t'(rdata);
	assign upd = psfs_pkg::apply_flit(rec, item_q);
	assign acc_next = psfs_pkg::accumulate(acc_q, psfs_pkg::stats_t'(rdata));
	assign sum_done = (cnt_q == item_q.fill[FILL_W-1:0]);
	assign load_out = (state_q == psfs_pkg::S_EMIT) && (!out_valid_q || stat_out.ready);

	always_comb begin
		pop = 1'b0;
		re = 1'b0;
		raddr = '0;
		we = 1'b0;
		case (state_q)
			psfs_pkg::S_IDLE: begin
				if (!queue_empty) begin
					pop = 1'b1;
					if (head_item.op == psfs_pkg::OP_UPDATE || head_item.op == psfs_pkg::OP_QUERY) begin
						re = 1'b1;
						raddr = head_item.idx[IDX_W-1:0];
					end else if (head_item.op == psfs_pkg::OP_TOTALS) begin
						re = 1'b1;
					end
				end
			end
			psfs_pkg::S_APPLY: begin
				we = (item_q.op != psfs_pkg::OP_QUERY);
			end
			psfs_pkg::S_SUM: begin
				if (!sum_done) begin
					re = 1'b1;
					raddr = cnt_q[IDX_W-1:0];
				end
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			psfs_pkg::S_IDLE: begin
				item_q <= head_item;
				acc_q <= '0;
				res_q.status <= head_item.status;
				res_q.stats <= '0;
				res_q.fill <= head_item.fill;
			end
			psfs_pkg::S_APPLY: begin
				res_q.stats <= (item_q.op == psfs_pkg::OP_QUERY) ? rec : upd;
			end
			psfs_pkg::S_SUM: begin
				acc_q <= acc_next;
				if (sum_done) begin
					res_q.stats <= acc_next;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
		if (load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psfs_pkg::S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				psfs_pkg::S_IDLE: begin
					cnt_q <= FILL_W'(1);
					if (!queue_empty) begin
						case (head_item.op)
							psfs_pkg::OP_NEW, psfs_pkg::OP_UPDATE, psfs_pkg::OP_QUERY: begin
								state_q <= psfs_pkg::S_APPLY;
							end
							psfs_pkg::OP_TOTALS: begin
								state_q <= (head_item.fill == '0) ? psfs_pkg::S_EMIT : psfs_pkg::S_SUM;
							end
							default: begin
								state_q <= psfs_pkg::S_EMIT;
							end
						endcase
					end
				end
				psfs_pkg::S_APPLY: begin
					state_q <= psfs_pkg::S_EMIT;
				end
				psfs_pkg::S_SUM: begin
					if (sum_done) begin
						state_q <= psfs_pkg::S_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				psfs_pkg::S_EMIT: begin
					if (load_out) begin
						state_q <= psfs_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= psfs_pkg::S_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (stat_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat_out.valid = out_valid_q;
	assign stat_out.status = out_q.status;
	assign stat_out.packet_count = out_q.stats.packets;
	assign stat_out.tail_count = out_q.stats.tails;
	assign stat_out.flit_count = out_q.stats.flits;
	assign stat_out.delay_sum = out_q.stats.delay_sum;
	assign stat_out.network_delay_sum = out_q.stats.net_delay_sum;
	assign stat_out.max_delay = out_q.stats.max_delay;
	assign stat_out.last_flit_time = out_q.stats.last_time;
	assign stat_out.sources_in_use = 6'(out_q.fill);
endmodule
